// ===== rtl/fbr_pkg.sv =====
// Shared types and constants of the framebuffer line and ellipse rasteriser.
`timescale 1ns / 1ps
`default_nettype none
package fbr_pkg;

   localparam int FB_BYTES = 1024;
   localparam int ADDR_W   = $clog2(FB_BYTES);
   localparam int BA_W     = 12;

   localparam logic [2:0] OP_PIXEL    = 3'd0;
   localparam logic [2:0] OP_LINE     = 3'd1;
   localparam logic [2:0] OP_ELLIPSE  = 3'd2;
   localparam logic [2:0] OP_RECT     = 3'd3;
   localparam logic [2:0] OP_FILL_ELL = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;
   localparam logic [2:0] OP_READ     = 3'd6;

   localparam logic [1:0] MODE_CLR  = 2'd0;
   localparam logic [1:0] MODE_SET  = 2'd1;
   localparam logic [1:0] MODE_XOR  = 2'd2;

   localparam logic CSR_FB_WIDTH = 1'b0;
   localparam logic CSR_FB_PAGES = 1'b1;

   typedef logic signed [11:0] coord_type;

   typedef enum logic [1:0] {K_PLOT, K_READ, K_CLEAR, K_END} kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [1:0]        mode;
      logic [11:0]       x;
      logic [11:0]       y;
      logic [BA_W-1:0]   addr;
   } pix_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [8:0]        x_a;
      logic [8:0]        y_a;
      logic [8:0]        x_b;
      logic [8:0]        y_b;
      logic [7:0]        radius_x;
      logic [7:0]        radius_y;
      logic [1:0]        mode;
      logic [9:0]        read_addr;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/fbr_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fbr_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/fbr_gen.sv =====
// Command sequencer: walks lines, ellipses, rectangles and sweeps as a pixel word stream.
`timescale 1ns / 1ps
`default_nettype none
module fbr_gen import fbr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start_i,
   input  wire cmd_type cmd_i,
   input  wire logic [7:0] fb_width_i,
   input  wire logic [3:0] fb_pages_i,
   output logic         busy_o,
   output pix_type      item_o
);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_END, S_LINE, S_E1, S_E2, S_E3, S_EPTS,
      S_EROW2, S_ESTEP, S_ETIP, S_RECT, S_HLINE
   } state_type;

   state_type        state_ff, ret_ff;
   pix_type          item_ff;
   logic             resp_ff, fill_ff;
   logic [1:0]       mode_ff, sub_ff;
   logic [BA_W-1:0]  idx_ff;
   coord_type        lx_ff, ly_ff, lx1_ff, ly1_ff, ldx_ff, ldy_ff, lerr_ff;
   logic             lsx_ff, lsy_ff;
   coord_type        xm_ff, ym_ff;
   logic [7:0]       ea_ff, eb_ff;
   logic signed [31:0] a2_ff, b2_ff, tx_ff, ty_ff, err_ff;
   logic [8:0]       dx_ff;
   logic signed [9:0] dy_ff;
   coord_type        rxp_ff, rxq_ff, ry_ff, ry2_ff;
   coord_type        hx_ff, hhi_ff, hy_ff;

   function automatic coord_type sx(logic [8:0] v);
      return {{3{v[8]}}, v};
   endfunction

   function automatic coord_type lo_of(coord_type p, coord_type q);
      coord_type m;
      m = (p < q) ? p : q;
      return (m < 0) ? 12'sd0 : m;
   endfunction

   function automatic coord_type hi_of(coord_type p, coord_type q, coord_type wl);
      coord_type m;
      m = (p > q) ? p : q;
      return (m > wl) ? wl : m;
   endfunction

   function automatic pix_type mk(kind_type k, logic [1:0] m, coord_type x, coord_type y,
                                  logic [BA_W-1:0] a);
      pix_type r;
      r.valid = 1'b1;
      r.kind  = k;
      r.mode  = m;
      r.x     = x;
      r.y     = y;
      r.addr  = a;
      return r;
   endfunction

   coord_type wl, ymax, c_x0, c_y0, c_x1, c_y1, c_dx, c_dy, c_ylo, c_yhi;
   coord_type exp_x, exm_x, eyp_y, eym_y;
   logic signed [12:0] le2;
   logic l_c1, l_c2;
   logic signed [31:0] e2, tx_in, ty_in, err1, err_in, tb;
   logic e_c1, e_c2;
   logic [8:0] dx_in;
   logic signed [9:0] dy_in;

   always_comb begin
      wl    = $signed({4'b0000, fb_width_i}) - 12'sd1;
      ymax  = $signed({5'b00000, fb_pages_i, 3'b000}) - 12'sd1;
      c_x0  = sx(cmd_i.x_a);
      c_y0  = sx(cmd_i.y_a);
      c_x1  = sx(cmd_i.x_b);
      c_y1  = sx(cmd_i.y_b);
      c_dx  = (c_x1 > c_x0) ? c_x1 - c_x0 : c_x0 - c_x1;
      c_dy  = (c_y1 > c_y0) ? c_y0 - c_y1 : c_y1 - c_y0;
      c_ylo = (c_y0 < c_y1) ? c_y0 : c_y1;
      c_ylo = (c_ylo < 0) ? 12'sd0 : c_ylo;
      c_yhi = (c_y0 > c_y1) ? c_y0 : c_y1;
      c_yhi = (c_yhi > ymax) ? ymax : c_yhi;

      le2  = {lerr_ff, 1'b0};
      l_c1 = le2 > $signed({ldy_ff[11], ldy_ff});
      l_c2 = le2 < $signed({ldx_ff[11], ldx_ff});

      exp_x = xm_ff + $signed({3'b000, dx_ff});
      exm_x = xm_ff - $signed({3'b000, dx_ff});
      eyp_y = ym_ff + {{2{dy_ff[9]}}, dy_ff};
      eym_y = ym_ff - {{2{dy_ff[9]}}, dy_ff};

      tb     = $signed({23'd0, eb_ff, 1'b0}) - 32'sd1;
      e2     = err_ff <<< 1;
      e_c1   = e2 < tx_ff;
      tx_in  = e_c1 ? tx_ff + (b2_ff <<< 1) : tx_ff;
      dx_in  = dx_ff + {8'd0, e_c1};
      err1   = e_c1 ? err_ff + tx_in : err_ff;
      e_c2   = e2 > -ty_ff;
      ty_in  = e_c2 ? ty_ff - (a2_ff <<< 1) : ty_ff;
      err_in = e_c2 ? err1 - ty_in : err1;
      dy_in  = dy_ff - {9'd0, e_c2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         ret_ff         <= S_IDLE;
         idx_ff         <= '0;
         resp_ff        <= 1'b0;
         item_ff.valid  <= 1'b0;
      end else begin
         item_ff.valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start_i) begin
                  mode_ff <= cmd_i.mode;
                  case (cmd_i.op)
                     OP_PIXEL: begin
                        item_ff  <= mk(K_PLOT, cmd_i.mode, c_x0, c_y0, '0);
                        state_ff <= S_END;
                     end
                     OP_READ: begin
                        item_ff  <= mk(K_READ, cmd_i.mode, '0, '0,
                                       {{(BA_W-10){1'b0}}, cmd_i.read_addr});
                        state_ff <= S_END;
                     end
                     OP_CLEAR: begin
                        idx_ff   <= '0;
                        resp_ff  <= 1'b1;
                        state_ff <= S_CLR;
                     end
                     OP_LINE: begin
                        lx_ff    <= c_x0;
                        ly_ff    <= c_y0;
                        lx1_ff   <= c_x1;
                        ly1_ff   <= c_y1;
                        ldx_ff   <= c_dx;
                        ldy_ff   <= c_dy;
                        lsx_ff   <= c_x0 < c_x1;
                        lsy_ff   <= c_y0 < c_y1;
                        lerr_ff  <= c_dx + c_dy;
                        state_ff <= S_LINE;
                     end
                     OP_ELLIPSE, OP_FILL_ELL: begin
                        xm_ff    <= c_x0;
                        ym_ff    <= c_y0;
                        ea_ff    <= cmd_i.radius_x;
                        eb_ff    <= cmd_i.radius_y;
                        fill_ff  <= cmd_i.op == OP_FILL_ELL;
                        state_ff <= S_E1;
                     end
                     OP_RECT: begin
                        rxp_ff   <= c_x0;
                        rxq_ff   <= c_x1;
                        ry_ff    <= c_ylo;
                        ry2_ff   <= c_yhi;
                        state_ff <= S_RECT;
                     end
                     default: state_ff <= S_END;
                  endcase
               end
            end
            S_CLR: begin
               item_ff <= mk(K_CLEAR, mode_ff, '0, '0, idx_ff);
               if (idx_ff == BA_W'(FB_BYTES - 1)) begin
                  state_ff <= resp_ff ? S_END : S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_END: begin
               item_ff  <= mk(K_END, mode_ff, '0, '0, '0);
               resp_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_LINE: begin
               item_ff <= mk(K_PLOT, mode_ff, lx_ff, ly_ff, '0);
               if (lx_ff == lx1_ff && ly_ff == ly1_ff) begin
                  state_ff <= S_END;
               end else begin
                  if (l_c1) lx_ff <= lsx_ff ? lx_ff + 12'sd1 : lx_ff - 12'sd1;
                  if (l_c2) ly_ff <= lsy_ff ? ly_ff + 12'sd1 : ly_ff - 12'sd1;
                  lerr_ff <= lerr_ff + (l_c1 ? ldy_ff : 12'sd0) + (l_c2 ? ldx_ff : 12'sd0);
               end
            end
            S_E1: begin
               a2_ff    <= $signed({16'd0, 16'(ea_ff * ea_ff)});
               b2_ff    <= $signed({16'd0, 16'(eb_ff * eb_ff)});
               state_ff <= S_E2;
            end
            S_E2: begin
               ty_ff    <= tb * a2_ff;
               tx_ff    <= b2_ff;
               dx_ff    <= '0;
               dy_ff    <= $signed({2'b00, eb_ff});
               state_ff <= S_E3;
            end
            S_E3: begin
               err_ff   <= b2_ff - ty_ff;
               sub_ff   <= '0;
               state_ff <= S_EPTS;
            end
            S_EPTS: begin
               if (fill_ff) begin
                  hx_ff    <= lo_of(exp_x, exm_x);
                  hhi_ff   <= hi_of(exp_x, exm_x, wl);
                  hy_ff    <= eyp_y;
                  ret_ff   <= S_EROW2;
                  state_ff <= S_HLINE;
               end else begin
                  case (sub_ff)
                     2'd0:    item_ff <= mk(K_PLOT, mode_ff, exp_x, eyp_y, '0);
                     2'd1:    item_ff <= mk(K_PLOT, mode_ff, exm_x, eyp_y, '0);
                     2'd2:    item_ff <= mk(K_PLOT, mode_ff, exm_x, eym_y, '0);
                     default: item_ff <= mk(K_PLOT, mode_ff, exp_x, eym_y, '0);
                  endcase
                  sub_ff <= sub_ff + 2'd1;
                  if (sub_ff == 2'd3) state_ff <= S_ESTEP;
               end
            end
            S_EROW2: begin
               hx_ff    <= lo_of(exm_x, exp_x);
               hhi_ff   <= hi_of(exm_x, exp_x, wl);
               hy_ff    <= eym_y;
               ret_ff   <= S_ESTEP;
               state_ff <= S_HLINE;
            end
            S_ESTEP: begin
               sub_ff <= '0;
               if (ea_ff == 8'd0 && eb_ff == 8'd0) begin
                  state_ff <= S_ETIP;
               end else begin
                  dx_ff    <= dx_in;
                  dy_ff    <= dy_in;
                  tx_ff    <= tx_in;
                  ty_ff    <= ty_in;
                  err_ff   <= err_in;
                  state_ff <= (dy_in >= 0) ? S_EPTS : S_ETIP;
               end
            end
            S_ETIP: begin
               if (dx_ff >= {1'b0, ea_ff}) begin
                  state_ff <= S_END;
               end else if (sub_ff == 2'd0) begin
                  item_ff <= mk(K_PLOT, mode_ff, exp_x + 12'sd1, ym_ff, '0);
                  sub_ff  <= 2'd1;
               end else begin
                  item_ff <= mk(K_PLOT, mode_ff, exm_x - 12'sd1, ym_ff, '0);
                  dx_ff   <= dx_ff + 9'd1;
                  sub_ff  <= 2'd0;
               end
            end
            S_RECT: begin
               if (ry_ff > ry2_ff) begin
                  state_ff <= S_END;
               end else begin
                  hx_ff    <= lo_of(rxp_ff, rxq_ff);
                  hhi_ff   <= hi_of(rxp_ff, rxq_ff, wl);
                  hy_ff    <= ry_ff;
                  ret_ff   <= S_RECT;
                  ry_ff    <= ry_ff + 12'sd1;
                  state_ff <= S_HLINE;
               end
            end
            S_HLINE: begin
               if (hx_ff > hhi_ff) begin
                  state_ff <= ret_ff;
               end else begin
                  item_ff <= mk(K_PLOT, mode_ff, hx_ff, hy_ff, '0);
                  if (hx_ff == hhi_ff) state_ff <= ret_ff;
                  else hx_ff <= hx_ff + 12'sd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy_o = (state_ff != S_IDLE) || item_ff.valid;
   assign item_o = item_ff;

endmodule
`default_nettype wire

// ===== rtl/fbr_pix.sv =====
// Pixel engine: address map, read-modify-write of the frame store with forwarding, response.
`timescale 1ns / 1ps
`default_nettype none
module fbr_pix import fbr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire pix_type    item_i,
   input  wire logic [7:0] fb_width_i,
   input  wire logic [3:0] fb_pages_i,
   output logic            busy_o,
   output logic            rsp_valid_o,
   output logic [7:0]      rsp_read_data_o
);

   logic              b_valid_ff, b_ok_ff, w_valid_ff;
   kind_type          b_kind_ff;
   logic [1:0]        b_mode_ff;
   logic [ADDR_W-1:0] b_addr_ff, w_addr_ff;
   logic [7:0]        b_bit_ff, w_data_ff, hold_ff;

   logic [12:0]       a13;
   logic              ok_in, in_x, in_y;
   logic [7:0]        bit_in, rdata, cur, wdata;
   logic              we;

   always_comb begin
      in_x = !item_i.x[11] && (item_i.x < {4'b0000, fb_width_i});
      in_y = !item_i.y[11] && (item_i.y[10:3] < {4'b0000, fb_pages_i});
      if (item_i.kind == K_PLOT) begin
         a13   = 13'(item_i.y[6:3] * fb_width_i) + 13'(item_i.x[7:0]);
         ok_in = in_x && in_y && (a13 < 13'(FB_BYTES));
      end else begin
         a13   = {1'b0, item_i.addr};
         ok_in = a13 < 13'(FB_BYTES);
      end
      bit_in = 8'h80 >> item_i.y[2:0];
   end

   fbr_ram #(.DEPTH(FB_BYTES), .WIDTH(8)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (b_addr_ff),
      .wdata (wdata),
      .raddr (a13[ADDR_W-1:0]),
      .rdata (rdata)
   );

   always_comb begin
      cur = (w_valid_ff && w_addr_ff == b_addr_ff) ? w_data_ff : rdata;
      case (b_mode_ff)
         MODE_CLR: wdata = cur & ~b_bit_ff;
         MODE_SET: wdata = cur | b_bit_ff;
         MODE_XOR: wdata = cur ^ b_bit_ff;
         default:  wdata = cur;
      endcase
      if (b_kind_ff == K_CLEAR) wdata = 8'h00;
      we = b_valid_ff && b_ok_ff && (b_kind_ff == K_PLOT || b_kind_ff == K_CLEAR);
   end

   always_ff @(posedge clock) begin
      b_kind_ff <= item_i.kind;
      b_ok_ff   <= ok_in;
      b_mode_ff <= item_i.mode;
      b_addr_ff <= a13[ADDR_W-1:0];
      b_bit_ff  <= bit_in;
      w_addr_ff <= b_addr_ff;
      w_data_ff <= wdata;
      if (reset) begin
         b_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
         hold_ff    <= 8'h00;
      end else begin
         b_valid_ff <= item_i.valid;
         w_valid_ff <= we;
         if (b_valid_ff && b_kind_ff == K_READ) begin
            hold_ff <= b_ok_ff ? cur : 8'h00;
         end else if (rsp_valid_o) begin
            hold_ff <= 8'h00;
         end
      end
   end

   assign busy_o          = b_valid_ff;
   assign rsp_valid_o     = b_valid_ff && (b_kind_ff == K_END);
   assign rsp_read_data_o = rsp_valid_o ? hold_ff : 8'h00;

endmodule
`default_nettype wire

// ===== rtl/framebuffer_line_ellipse_rasterizer_top.sv =====
// Pixel command: the sequencer registers the pixel and end words in turn, and the pixel
// engine registers the end word and raises the response. Ellipses pass setup states
// S_E1, S_E2, S_E3, then S_ESTEP at each step. Clear sweeps FB_BYTES words. One command
// at a time; the sequencer emits at most one pixel per cycle into a pipelined frame
// store read-modify-write with forwarding. After reset the store is swept to zero with
// busy high. The response strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module framebuffer_line_ellipse_rasterizer_top import fbr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_op,
   input  wire logic signed [8:0] req_x_a,
   input  wire logic signed [8:0] req_y_a,
   input  wire logic signed [8:0] req_x_b,
   input  wire logic signed [8:0] req_y_b,
   input  wire logic [7:0]        req_radius_x,
   input  wire logic [7:0]        req_radius_y,
   input  wire logic [1:0]        req_pixel_mode,
   input  wire logic [9:0]        req_read_addr,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_read_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata
);

   logic [7:0] fb_width_ff;
   logic [3:0] fb_pages_ff;
   logic       gen_busy, pix_busy, accept;
   cmd_type    cmd;
   pix_type    item;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff <= 8'd128;
         fb_pages_ff <= 4'd8;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FB_WIDTH: fb_width_ff <= csr_wdata;
            CSR_FB_PAGES: fb_pages_ff <= csr_wdata[3:0];
            default:      fb_width_ff <= fb_width_ff;
         endcase
      end
   end

   assign accept = start && !busy;
   assign busy   = gen_busy || pix_busy;

   always_comb begin
      cmd.op        = req_op;
      cmd.x_a       = req_x_a;
      cmd.y_a       = req_y_a;
      cmd.x_b       = req_x_b;
      cmd.y_b       = req_y_b;
      cmd.radius_x  = req_radius_x;
      cmd.radius_y  = req_radius_y;
      cmd.mode      = req_pixel_mode;
      cmd.read_addr = req_read_addr;
   end

   fbr_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .start_i    (accept),
      .cmd_i      (cmd),
      .fb_width_i (fb_width_ff),
      .fb_pages_i (fb_pages_ff),
      .busy_o     (gen_busy),
      .item_o     (item)
   );

   fbr_pix u_pix (
      .clock           (clock),
      .reset           (reset),
      .item_i          (item),
      .fb_width_i      (fb_width_ff),
      .fb_pages_i      (fb_pages_ff),
      .busy_o          (pix_busy),
      .rsp_valid_o     (rsp_valid),
      .rsp_read_data_o (rsp_read_data)
   );

endmodule
`default_nettype wire

// ===== rtl/fbr_chk.sv =====
// Port-level checker for the rasteriser top level and its bind.
`timescale 1ns / 1ps
`default_nettype none
module fbr_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy low after accepted word");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && $past(busy)) else $error("response outside command");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe repeated");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after response");

endmodule

bind framebuffer_line_ellipse_rasterizer_top fbr_chk u_fbr_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
`default_nettype wire
